// ----- design/assert_macros.svh -----
// Assertion helpers used by the top-level RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AST_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define AST_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/uxe_pkg.sv -----
package uxe_pkg;

  // Entity match phase
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_AMP     = 4'd1,
    PH_AMP_L   = 4'd2,
    PH_AMP_LT  = 4'd3,
    PH_AMP_A   = 4'd4,
    PH_AMP_AM  = 4'd5,
    PH_AMP_AMP = 4'd6,
    PH_NUM_WS  = 4'd7,
    PH_NUM_DIG = 4'd8,
    PH_SKIP    = 4'd9
  } phase_t;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_T     = 8'h74;

  localparam int MAX_RES = 4;

  // One queued run: the results caused by one input byte
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;   // result bytes, first in entry 0
    logic [1:0]              cnt_m1;  // result count minus one
    logic                    has_byte; // 0 only for the empty end-of-string result
    logic                    is_end;   // run closes the string
  } run_t;

  // Queue status toward front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

// ----- design/xml_entity_unescaper_top.sv -----
// An input transfer writes its results into the run queue, from which the first one
// moves into the output register when the output register advances.
// Throughput: one input byte per cycle while the run queue is not full; each result
// takes one output transfer, so a byte that causes k results holds the output for k
// transfers (the 4-entry run queue absorbs this). Reset: synchronous rst clears match
// state, queue pointers and the output valid; the block is ready for input once reset ends.
module xml_entity_unescaper_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic       m_tlast,   // run_last
  output logic [1:0] m_tuser    // [0] byte_valid, [1] stream_end
);
  import uxe_pkg::*;

  `include "assert_macros.svh"

  q_stat_t q_stat;
  run_t    push_run, head;
  logic    push, pop;

  uxe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .q_stat   (q_stat),
    .push     (push),
    .push_run (push_run)
  );

  uxe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  uxe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Input stalls only on a full queue
  `AST_IMPLY(a_ready_full, clk, rst, !s_tready, q_stat.full)
  // End of string always closes a run
  `AST_IMPLY(a_end_last, clk, rst, m_tvalid && m_tuser[1], m_tlast)
  // An empty result appears only as the zero end-of-string marker
  `AST_IMPLY(a_empty_end, clk, rst, m_tvalid && !m_tuser[0], m_tuser[1] && (m_tdata == 8'd0))
  // A pop always moves a result into the output register
  `AST_NEXT(a_pop_out, clk, rst, pop, m_tvalid && m_tlast)

endmodule

// ----- design/uxe_front.sv -----
module uxe_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  uxe_pkg::q_stat_t q_stat,
  output logic          push,
  output uxe_pkg::run_t push_run
);
  import uxe_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] num_val, num_val_next;
  logic       num_neg, num_neg_next;

  logic             accept;
  logic [MAX_RES-1:0][7:0] e;
  logic [2:0]       n;
  logic             do_idle;
  logic             is_digit, is_ws;
  logic [7:0]       digit, num_byte;
  logic [7:0]       acc;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign is_ws     = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));
  assign digit     = in_byte - CH_ZERO;
  assign num_byte  = num_neg ? 8'(8'd0 - num_val) : num_val;
  assign acc       = 8'({num_val, 3'b000} + {num_val, 1'b0} + digit);

  // Classify the byte and build its run of results
  always_comb begin
    e            = '0;
    n            = 3'd0;
    do_idle      = 1'b0;
    phase_next   = phase;
    num_val_next = num_val;
    num_neg_next = num_neg;

    unique case (phase)
      PH_AMP: begin
        if (in_byte == CH_L) begin
          phase_next = PH_AMP_L;
        end else if (in_byte == CH_A) begin
          e[n[1:0]] = CH_AMP; n = n + 3'd1;
          phase_next = PH_AMP_A;
        end else if (in_byte == CH_HASH) begin
          phase_next   = PH_NUM_WS;
          num_val_next = 8'd0;
          num_neg_next = 1'b0;
        end else begin
          e[n[1:0]] = CH_AMP; n = n + 3'd1;
          do_idle = 1'b1;
        end
      end
      PH_AMP_L: begin
        if (in_byte == CH_T) begin
          phase_next = PH_AMP_LT;
        end else begin
          e[n[1:0]] = CH_AMP; n = n + 3'd1;
          e[n[1:0]] = CH_L;   n = n + 3'd1;
          do_idle = 1'b1;
        end
      end
      PH_AMP_LT: begin
        if (in_byte == CH_SEMI) begin
          e[n[1:0]] = CH_LT; n = n + 3'd1;
          phase_next = PH_IDLE;
        end else begin
          e[n[1:0]] = CH_AMP; n = n + 3'd1;
          e[n[1:0]] = CH_L;   n = n + 3'd1;
          e[n[1:0]] = CH_T;   n = n + 3'd1;
          do_idle = 1'b1;
        end
      end
      PH_AMP_A: begin
        if (in_byte == CH_M) begin
          phase_next = PH_AMP_AM;
        end else begin
          e[n[1:0]] = CH_A; n = n + 3'd1;
          do_idle = 1'b1;
        end
      end
      PH_AMP_AM: begin
        if (in_byte == CH_P) begin
          phase_next = PH_AMP_AMP;
        end else begin
          e[n[1:0]] = CH_A; n = n + 3'd1;
          e[n[1:0]] = CH_M; n = n + 3'd1;
          do_idle = 1'b1;
        end
      end
      PH_AMP_AMP: begin
        if (in_byte == CH_SEMI) begin
          phase_next = PH_IDLE;
        end else begin
          e[n[1:0]] = CH_A; n = n + 3'd1;
          e[n[1:0]] = CH_M; n = n + 3'd1;
          e[n[1:0]] = CH_P; n = n + 3'd1;
          do_idle = 1'b1;
        end
      end
      PH_NUM_WS: begin
        if (is_ws) begin
          phase_next = PH_NUM_WS;
        end else if (in_byte == CH_PLUS) begin
          phase_next = PH_NUM_DIG;
        end else if (in_byte == CH_MINUS) begin
          num_neg_next = 1'b1;
          phase_next   = PH_NUM_DIG;
        end else if (is_digit) begin
          num_val_next = digit;
          phase_next   = PH_NUM_DIG;
        end else begin
          e[n[1:0]] = num_byte; n = n + 3'd1;
          phase_next = (in_byte == CH_SEMI) ? PH_IDLE : PH_SKIP;
        end
      end
      PH_NUM_DIG: begin
        if (is_digit) begin
          num_val_next = acc;
        end else begin
          e[n[1:0]] = num_byte; n = n + 3'd1;
          phase_next = (in_byte == CH_SEMI) ? PH_IDLE : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (in_byte == CH_SEMI) phase_next = PH_IDLE;
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // Restart matching at the failing byte
    if (do_idle) begin
      if (in_byte == CH_AMP) begin
        phase_next = PH_AMP;
      end else begin
        e[n[1:0]] = in_byte; n = n + 3'd1;
        phase_next = PH_IDLE;
      end
    end

    // End of string: flush whatever is pending, then back to reset state
    if (in_last) begin
      unique case (phase_next)
        PH_AMP: begin
          e[n[1:0]] = CH_AMP; n = n + 3'd1;
        end
        PH_AMP_L: begin
          e[n[1:0]] = CH_AMP; n = n + 3'd1;
          e[n[1:0]] = CH_L;   n = n + 3'd1;
        end
        PH_AMP_LT: begin
          e[n[1:0]] = CH_AMP; n = n + 3'd1;
          e[n[1:0]] = CH_L;   n = n + 3'd1;
          e[n[1:0]] = CH_T;   n = n + 3'd1;
        end
        PH_AMP_A: begin
          e[n[1:0]] = CH_A; n = n + 3'd1;
        end
        PH_AMP_AM: begin
          e[n[1:0]] = CH_A; n = n + 3'd1;
          e[n[1:0]] = CH_M; n = n + 3'd1;
        end
        PH_AMP_AMP: begin
          e[n[1:0]] = CH_A; n = n + 3'd1;
          e[n[1:0]] = CH_M; n = n + 3'd1;
          e[n[1:0]] = CH_P; n = n + 3'd1;
        end
        PH_NUM_WS, PH_NUM_DIG: begin
          e[n[1:0]] = num_neg_next ? 8'(8'd0 - num_val_next) : num_val_next;
          n = n + 3'd1;
        end
        default: begin
        end
      endcase
      phase_next   = PH_IDLE;
      num_val_next = 8'd0;
      num_neg_next = 1'b0;
    end
  end

  // Queue entry for this byte
  always_comb begin
    push              = accept && ((n != 3'd0) || in_last);
    push_run.bytes    = e;
    push_run.cnt_m1   = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
    push_run.has_byte = (n != 3'd0);
    push_run.is_end   = in_last;
  end

  // Match state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      num_val <= 8'd0;
      num_neg <= 1'b0;
    end else if (accept) begin
      phase   <= phase_next;
      num_val <= num_val_next;
      num_neg <= num_neg_next;
    end
  end

endmodule

// ----- design/uxe_queue.sv -----
module uxe_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  uxe_pkg::run_t    push_run,
  input  logic             pop,
  output uxe_pkg::run_t    head,
  output uxe_pkg::q_stat_t stat
);
  import uxe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  run_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign stat.full      = (count == CW'(DEPTH));
  assign stat.not_empty = (count != '0);
  assign do_push        = push && !stat.full;
  assign do_pop         = pop && stat.not_empty;
  assign head           = mem[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_run;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule

// ----- design/uxe_back.sv -----
module uxe_back (
  input  logic             clk,
  input  logic             rst,
  input  uxe_pkg::run_t    head,
  input  uxe_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // out_byte
  output logic             m_tlast,   // run_last
  output logic [1:0]       m_tuser    // [0] byte_valid, [1] stream_end
);
  import uxe_pkg::*;

  logic [1:0] pos;
  logic       advance, run_done;

  assign advance  = !m_tvalid || m_tready;
  assign run_done = (pos == head.cnt_m1);
  assign pop      = advance && q_stat.not_empty && run_done;

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pos      <= 2'd0;
    end else if (advance) begin
      m_tvalid <= q_stat.not_empty;
      if (q_stat.not_empty) pos <= run_done ? 2'd0 : pos + 2'd1;
    end
  end

  // Output payload, one result of the head run per transfer
  always_ff @(posedge clk) begin
    if (advance && q_stat.not_empty) begin
      m_tdata    <= head.bytes[pos];
      m_tlast    <= run_done;
      m_tuser[0] <= head.has_byte;
      m_tuser[1] <= head.is_end && run_done;
    end
  end

endmodule
